### sv/lmsb_pkg.sv
// lmsb_pkg: shared types, defaults and helpers for the led matrix scan buffer
// used by led_matrix_scan_buffer_unit and its checker; no dependencies
package lmsb_pkg;

	// default matrix size
	localparam int COLUMNS_DEF = 64;
	localparam int ROWS_DEF    = 16;

	// fixed field widths
	localparam int X_W      = 6;
	localparam int Y_W      = 4;
	localparam int VALUE_W  = 8;
	localparam int ROWBITS_W = 64;
	localparam int SELECT_W = 4;
	localparam int ROWNUM_W = 4;

	// input operation codes
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_SCAN  = 1'b1
	} op_t;

	// 2-bit gray code, high bit first: 0->00, 1->10, 2->11, 3->01
	function automatic logic [1:0] gray2(input logic [1:0] k);
		gray2 = {k[1] ^ k[0], k[1]};
	endfunction

	// select pins PA,PB,NA,NB for a row index
	function automatic logic [SELECT_W-1:0] row_select_code(input logic [ROWNUM_W-1:0] r);
		row_select_code = {gray2(r[3:2]), gray2(r[1:0])};
	endfunction

endpackage

### sv/led_matrix_scan_buffer_unit.sv
// led_matrix_scan_buffer_unit: frame store and row scanner for a multiplexed led matrix
// depends on lmsb_pkg (widths, operation codes, gray select encoding)
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall  | operation, pixel_x, pixel_y, pixel_value
//  out     | output    | out_valid/out_stall| row_bits, row_select, scanned_row
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data (low_active)
//
// one item per cycle while in_stall is low: an item is taken into the input register, and
// from there a pixel write updates one bit of the flip-flop frame store or a scan tick
// loads the output register.
// reset sets the frame store to all ones, the scan row to zero and low_active to one.
// in_stall rises only while a scan tick waits in the input register behind a stalled
// result; pixel writes never wait.
module led_matrix_scan_buffer_unit #(
	parameter int COLUMNS = lmsb_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmsb_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [lmsb_pkg::X_W-1:0]        pixel_x,
	input  logic [lmsb_pkg::Y_W-1:0]        pixel_y,
	input  logic [lmsb_pkg::VALUE_W-1:0]    pixel_value,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lmsb_pkg::ROWBITS_W-1:0]  row_bits,
	output logic [lmsb_pkg::SELECT_W-1:0]   row_select,
	output logic [lmsb_pkg::ROWNUM_W-1:0]   scanned_row,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data
);
	import lmsb_pkg::*;

	localparam int BYTES   = COLUMNS / 8;
	localparam int STORE_W = 8 * BYTES;
	localparam int BIT_W   = $clog2(STORE_W);
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

	// state
	logic [STORE_W-1:0]   store_q [ROWS];
	logic [ROW_W-1:0]     scan_row_q;
	logic                 low_active_q;

	// input register
	logic                 valid_s1;
	op_t                  op_s1;
	logic [X_W-1:0]       x_s1;
	logic [Y_W-1:0]       y_s1;
	logic [VALUE_W-1:0]   value_s1;

	// output register
	logic                 out_valid_q;
	logic [ROWBITS_W-1:0] row_bits_q;
	logic [SELECT_W-1:0]  row_select_q;
	logic [ROWNUM_W-1:0]  scanned_row_q;

	// stage control
	logic                 out_free;
	logic                 s1_go;
	logic                 in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && ((op_s1 == OP_WRITE) || out_free);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_active_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			low_active_q <= cfg_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= op_t'(operation);
			x_s1     <= pixel_x;
			y_s1     <= pixel_y;
			value_s1 <= pixel_value;
		end
	end

	// pixel write address decode
	logic [X_W:0]   col_diff;
	logic [3:0]     byte_idx;
	logic [X_W:0]   bit_full;
	logic [Y_W:0]   row_full;
	logic           wr_in_range;
	logic           wr_en;
	logic           pix_selected;
	logic [BIT_W-1:0] wr_bit;
	logic [ROW_W-1:0] wr_row;

	always_comb begin
		col_diff     = (X_W+1)'(COLUMNS - 1) - {1'b0, x_s1};
		byte_idx     = col_diff[X_W:3];
		bit_full     = {byte_idx, x_s1[2:0]};
		row_full     = (Y_W+1)'(ROWS - 1) - {1'b0, y_s1};
		wr_in_range  = ({1'b0, x_s1} < (X_W+1)'(COLUMNS))
			&& ({1'b0, y_s1} < (Y_W+1)'(ROWS))
			&& (byte_idx < 4'(BYTES));
		wr_en        = s1_go && (op_s1 == OP_WRITE) && wr_in_range;
		pix_selected = low_active_q ? (value_s1 == '0) : (value_s1 != '0);
		wr_bit       = bit_full[BIT_W-1:0];
		wr_row       = row_full[ROW_W-1:0];
	end

	// frame store, a lit pixel stores a zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				store_q[r] <= '1;
			end
		end else if (wr_en) begin
			store_q[wr_row][wr_bit] <= !pix_selected;
		end
	end

	// scan row counter, wraps at the last row
	logic scan_go;
	assign scan_go = s1_go && (op_s1 == OP_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
		end else if (scan_go) begin
			if (scan_row_q == ROW_W'(ROWS - 1)) begin
				scan_row_q <= '0;
			end else begin
				scan_row_q <= scan_row_q + 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (scan_go) begin
			row_bits_q    <= ROWBITS_W'(store_q[scan_row_q]);
			row_select_q  <= row_select_code(ROWNUM_W'(scan_row_q));
			scanned_row_q <= ROWNUM_W'(scan_row_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign row_bits    = row_bits_q;
	assign row_select  = row_select_q;
	assign scanned_row = scanned_row_q;

endmodule

### sv/lmsb_checker.sv
// lmsb_checker: port-level assertions for led_matrix_scan_buffer_unit, bound to the top
// depends on lmsb_pkg (row select encoding, widths)
module lmsb_checker #(
	parameter int COLUMNS = lmsb_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmsb_pkg::ROWS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [lmsb_pkg::ROWBITS_W-1:0]  row_bits,
	input logic [lmsb_pkg::SELECT_W-1:0]   row_select,
	input logic [lmsb_pkg::ROWNUM_W-1:0]   scanned_row
);
	import lmsb_pkg::*;

	localparam int STORE_W = 8 * (COLUMNS / 8);

	logic [ROWBITS_W-1:0] high_mask;
	assign high_mask = (STORE_W >= ROWBITS_W) ? '0 : ~((ROWBITS_W'(1) << STORE_W) - 1'b1);

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_bits) && $stable(scanned_row))
		else $error("stalled result changed");

	// input waits only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// select pins match the gray code of the scanned row
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_select == row_select_code(scanned_row))
		else $error("row select does not match scanned row");

	// scanned row stays inside the matrix and unused columns read zero
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(scanned_row) < ROWS) && ((row_bits & high_mask) == '0))
		else $error("scanned row or row bits out of range");

endmodule

bind led_matrix_scan_buffer_unit lmsb_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_lmsb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.row_bits    (row_bits),
	.row_select  (row_select),
	.scanned_row (scanned_row)
);
